// ----- rtl/kdlp_pkg.sv -----
// Shared types, key tables and character helpers for the keyed decimal line parser.
// No dependencies; imported by kdlp_parser, kdlp_skid and keyed_decimal_line_parser.
package kdlp_pkg;

    localparam int NumKeys = 6;
    localparam int KeyIdxW = 3;
    localparam int PosW    = 3;
    localparam int HeadLen = 3;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } kdlp_in_t;

    typedef struct packed {
        logic               line_ok;
        logic signed [15:0] level_inside;
        logic signed [15:0] level_outside;
        logic signed [15:0] level_threshold;
        logic [7:0]         count_inside;
        logic [7:0]         count_outside;
        logic [7:0]         count_threshold;
        logic [2:0]         health_mask;
    } kdlp_out_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_REJECT,
        PH_KEY,
        PH_SKIP,
        PH_NUMPRE,
        PH_NUMDIG,
        PH_HALT
    } kdlp_phase_t;

    // key slots: in, out, th, ni, no, nt
    localparam logic [KeyIdxW-1:0] KEY_IN  = 3'd0;
    localparam logic [KeyIdxW-1:0] KEY_OUT = 3'd1;
    localparam logic [KeyIdxW-1:0] KEY_TH  = 3'd2;
    localparam logic [KeyIdxW-1:0] KEY_NI  = 3'd3;
    localparam logic [KeyIdxW-1:0] KEY_NO  = 3'd4;
    localparam logic [KeyIdxW-1:0] KEY_NT  = 3'd5;

    localparam logic [NumKeys-1:0] ALL_KEYS = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // "SF1"
    localparam logic [7:0] HEAD_TEXT [HeadLen] = '{8'h53, 8'h46, 8'h31};

    // "in=", "out=", "th=", "ni=", "no=", "nt="
    localparam logic [7:0] KEY_TEXT [NumKeys][4] = '{
        '{8'h69, 8'h6E, 8'h3D, 8'h00},
        '{8'h6F, 8'h75, 8'h74, 8'h3D},
        '{8'h74, 8'h68, 8'h3D, 8'h00},
        '{8'h6E, 8'h69, 8'h3D, 8'h00},
        '{8'h6E, 8'h6F, 8'h3D, 8'h00},
        '{8'h6E, 8'h74, 8'h3D, 8'h00}
    };
    localparam logic [PosW-1:0] KEY_LEN [NumKeys] = '{3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3};

    typedef struct packed {
        kdlp_phase_t         phase;
        logic [PosW-1:0]     pos;
        logic [NumKeys-1:0]  cand;
        logic                hit;
        logic [KeyIdxW-1:0]  key;
    } kdlp_feed_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// ----- rtl/kdlp_parser.sv -----
// Per-character parse state: prefix check, key match, decimal accumulate, line result.
// Depends on kdlp_pkg.
module kdlp_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_valid,
    input  kdlp_pkg::kdlp_in_t beat,
    output logic               result_valid,
    output kdlp_pkg::kdlp_out_t result
);
    import kdlp_pkg::*;

    kdlp_phase_t          phase_reg,  phase_next;
    logic [PosW-1:0]      pos_reg,    pos_next;
    logic [NumKeys-1:0]   cand_reg,   cand_next;
    logic [KeyIdxW-1:0]   active_reg, active_next;
    logic [31:0]          acc_reg,    acc_next;
    logic                 neg_reg,    neg_next;
    logic                 sign_reg,   sign_next;
    logic [31:0]          field_reg [NumKeys];
    logic [31:0]          field_next [NumKeys];

    logic [7:0]  c;
    kdlp_feed_t  feed_cur;
    kdlp_feed_t  feed_tok;
    logic [3:0]  digit_full;
    logic [35:0] acc_x10;
    logic [31:0] acc_sat;
    logic [31:0] dig_value;

    function automatic kdlp_feed_t key_feed(input logic [7:0] ch,
                                            input logic [PosW-1:0] pos,
                                            input logic [NumKeys-1:0] cand);
        kdlp_feed_t         f;
        logic [NumKeys-1:0] keep;
        logic [PosW-1:0]    pos_inc;
        keep    = '0;
        pos_inc = pos + 3'd1;
        for (int k = 0; k < NumKeys; k++) begin
            if (cand[k] && (pos < KEY_LEN[k]) && (KEY_TEXT[k][pos[1:0]] == ch)) begin
                keep[k] = 1'b1;
            end
        end
        f.phase = PH_KEY;
        f.pos   = pos;
        f.cand  = cand;
        f.hit   = 1'b0;
        f.key   = '0;
        if (keep == '0) begin
            if (is_space(ch)) begin
                f.pos  = '0;
                f.cand = ALL_KEYS;
            end else begin
                f.phase = PH_SKIP;
            end
        end else begin
            f.pos  = pos_inc;
            f.cand = keep;
            for (int k = 0; k < NumKeys; k++) begin
                if (keep[k] && (KEY_LEN[k] == pos_inc)) begin
                    f.hit   = 1'b1;
                    f.key   = KeyIdxW'(k);
                    f.phase = PH_NUMPRE;
                end
            end
        end
        return f;
    endfunction

    assign c        = beat.char_code;
    assign feed_cur = key_feed(c, pos_reg, cand_reg);
    assign feed_tok = key_feed(c, '0, ALL_KEYS);

    // acc * 10 + digit, clipped at 2^31 magnitude
    always_comb begin
        // digits are 0x30..0x39, so the low nibble carries the value
        digit_full = c[3:0] - CH_ZERO[3:0];
        acc_x10    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                   + {32'b0, digit_full};
        acc_sat    = (acc_x10 > 36'h0_8000_0000) ? 32'h8000_0000 : acc_x10[31:0];
        if (neg_reg) begin
            dig_value = 32'd0 - acc_sat;
        end else begin
            dig_value = acc_sat[31] ? 32'h7FFF_FFFF : acc_sat;
        end
    end

    // next state
    always_comb begin
        kdlp_feed_t f;
        logic       use_feed;
        logic       use_digit;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        active_next = active_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        sign_next   = sign_reg;
        field_next  = field_reg;
        f           = feed_cur;
        use_feed    = 1'b0;
        use_digit   = 1'b0;

        if (beat_valid) begin
            if (beat.line_end) begin
                phase_next  = PH_START;
                pos_next    = '0;
                cand_next   = ALL_KEYS;
                active_next = '0;
                acc_next    = '0;
                neg_next    = 1'b0;
                sign_next   = 1'b0;
                for (int k = 0; k < NumKeys; k++) begin
                    field_next[k] = '0;
                end
            end else if (c == CH_NUL) begin
                // NUL ends the text; rest of the line is ignored
                if (phase_reg == PH_START) begin
                    phase_next = PH_REJECT;
                end else if (phase_reg != PH_REJECT) begin
                    phase_next = PH_HALT;
                end
            end else begin
                unique case (phase_reg)
                    PH_START: begin
                        if (!(pos_reg == '0 && is_space(c))) begin
                            if ((pos_reg < PosW'(HeadLen))
                                && (HEAD_TEXT[pos_reg[1:0]] == c)) begin
                                if (pos_reg == PosW'(HeadLen - 1)) begin
                                    phase_next = PH_KEY;
                                    pos_next   = '0;
                                    cand_next  = ALL_KEYS;
                                end else begin
                                    pos_next = pos_reg + 3'd1;
                                end
                            end else begin
                                phase_next = PH_REJECT;
                            end
                        end
                    end
                    PH_KEY: begin
                        f        = feed_cur;
                        use_feed = 1'b1;
                    end
                    PH_SKIP: begin
                        if (is_space(c)) begin
                            phase_next = PH_KEY;
                            pos_next   = '0;
                            cand_next  = ALL_KEYS;
                        end
                    end
                    PH_NUMPRE: begin
                        if (is_digit(c)) begin
                            use_digit = 1'b1;
                        end else if (sign_reg) begin
                            if (is_space(c)) begin
                                phase_next = PH_KEY;
                                pos_next   = '0;
                                cand_next  = ALL_KEYS;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end else if (c == CH_PLUS || c == CH_MINUS) begin
                            sign_next = 1'b1;
                            neg_next  = (c == CH_MINUS);
                        end else if (!is_space(c)) begin
                            f        = feed_tok;
                            use_feed = 1'b1;
                        end
                    end
                    PH_NUMDIG: begin
                        if (is_digit(c)) begin
                            use_digit = 1'b1;
                        end else begin
                            f        = feed_tok;
                            use_feed = 1'b1;
                        end
                    end
                    PH_REJECT, PH_HALT: begin
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (use_feed) begin
            phase_next = f.phase;
            pos_next   = f.pos;
            cand_next  = f.cand;
            if (f.hit) begin
                active_next         = f.key;
                field_next[f.key]   = '0;
                acc_next            = '0;
                neg_next            = 1'b0;
                sign_next           = 1'b0;
            end
        end

        if (use_digit) begin
            acc_next               = acc_sat;
            field_next[active_reg] = dig_value;
            phase_next             = PH_NUMDIG;
        end
    end

    // line result, taken on the line_end beat
    always_comb begin
        logic pi, po, pt;
        logic line_open;
        line_open = (phase_reg != PH_START) && (phase_reg != PH_REJECT);
        pi = (field_reg[KEY_NI] != '0) && !field_reg[KEY_NI][31];
        po = (field_reg[KEY_NO] != '0) && !field_reg[KEY_NO][31];
        pt = (field_reg[KEY_NT] != '0) && !field_reg[KEY_NT][31];
        result = '0;
        if (line_open) begin
            result.line_ok         = pi || po;
            result.level_inside    = pi ? field_reg[KEY_IN][15:0]  : 16'h8000;
            result.level_outside   = po ? field_reg[KEY_OUT][15:0] : 16'h8000;
            result.level_threshold = pt ? field_reg[KEY_TH][15:0]  : 16'h8000;
            result.count_inside    = !pi ? 8'd0 : ((field_reg[KEY_NI] > 32'd255) ? 8'd255
                                                   : field_reg[KEY_NI][7:0]);
            result.count_outside   = !po ? 8'd0 : ((field_reg[KEY_NO] > 32'd255) ? 8'd255
                                                   : field_reg[KEY_NO][7:0]);
            result.count_threshold = !pt ? 8'd0 : ((field_reg[KEY_NT] > 32'd255) ? 8'd255
                                                   : field_reg[KEY_NT][7:0]);
            result.health_mask     = {pt, po, pi};
        end
        result_valid = beat_valid && beat.line_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            pos_reg    <= '0;
            cand_reg   <= ALL_KEYS;
            active_reg <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            sign_reg   <= 1'b0;
            for (int k = 0; k < NumKeys; k++) begin
                field_reg[k] <= '0;
            end
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            active_reg <= active_next;
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            sign_reg   <= sign_next;
            field_reg  <= field_next;
        end
    end

endmodule

// ----- rtl/kdlp_skid.sv -----
// Two-entry result buffer: output register plus skid register.
// Depends on kdlp_pkg for the result type.
module kdlp_skid (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  kdlp_pkg::kdlp_out_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kdlp_pkg::kdlp_out_t out_data
);
    import kdlp_pkg::*;

    logic      main_valid_reg,  main_valid_next;
    logic      spare_valid_reg, spare_valid_next;
    kdlp_out_t main_reg,  main_next;
    kdlp_out_t spare_reg, spare_next;

    assign in_ready  = !spare_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_next        = main_reg;
        spare_next       = spare_reg;
        if (!main_valid_reg || out_ready) begin
            if (spare_valid_reg) begin
                main_next        = spare_reg;
                main_valid_next  = 1'b1;
                spare_valid_next = 1'b0;
            end else begin
                main_next       = in_data;
                main_valid_next = in_valid;
            end
        end else if (in_valid && in_ready) begin
            // output stalled: park the beat
            spare_next       = in_data;
            spare_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

endmodule

// ----- rtl/keyed_decimal_line_parser.sv -----
// A line_end result is registered in the output register, or the skid register on a stall.
// One character beat per cycle while s_ready is high; parse state is registered per beat.
// s_ready drops only when both the output register and the skid register hold results.
// Reset (aresetn low, synchronous) returns the parser to line start and empties the buffer.
// Depends on kdlp_pkg, kdlp_parser and kdlp_skid.
module keyed_decimal_line_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  kdlp_pkg::kdlp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output kdlp_pkg::kdlp_out_t m_data
);
    import kdlp_pkg::*;

    logic      beat_valid;
    logic      res_valid;
    kdlp_out_t res_data;
    logic      buf_ready;

    assign s_ready    = buf_ready;
    assign beat_valid = s_valid && buf_ready;

    kdlp_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_valid   (beat_valid),
        .beat         (s_data),
        .result_valid (res_valid),
        .result       (res_data)
    );

    kdlp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (buf_ready),
        .in_data   (res_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_line_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.line_end) |=> m_valid)
        else $error("line_end beat produced no result");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !$past(m_ready)))
        else $error("input stalled while output buffer not full");

    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(s_valid && s_ready && s_data.line_end)) |=> !m_valid)
        else $error("result without a line_end beat");

    a_ok_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.line_ok == (m_data.health_mask[0] || m_data.health_mask[1])))
        else $error("line_ok disagrees with health_mask");
`endif

endmodule
